>>> rtl/core/tpd_pkg.sv
// tpd_pkg: shared types and constants for the touch press detector
// register index codes, reset values and the configuration bundle
// no dependencies
package tpd_pkg;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // register index codes
  localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRESS_RATIO = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GLITCH_NEAR = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_GLITCH_FAR  = 3'd4;

  // register reset values
  localparam logic [15:0] ALPHA_RST       = 16'd62259;
  localparam logic [15:0] PRESS_RATIO_RST = 16'd58982;
  localparam logic [15:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [15:0] GLITCH_NEAR_RST = 16'd5;
  localparam logic [15:0] GLITCH_FAR_RST  = 16'd3;

  typedef struct packed {
    logic [15:0] smoothing_alpha_q16;
    logic [15:0] press_ratio_q16;
    logic [15:0] debounce_ms;
    logic [15:0] glitch_near;
    logic [15:0] glitch_far;
  } tpd_cfg_t;

  // raw press status from the filter to the debounce stage
  typedef struct packed {
    logic raw;
    logic raw_changed;
  } tpd_raw_t;

endpackage

>>> rtl/core/tpd_filter.sv
// tpd_filter: glitch repair, sample history, baseline tracking and raw press compare
// state advances once per processed sample request
// depends on tpd_pkg
module tpd_filter #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  tpd_pkg::tpd_cfg_t      cfg,
  output tpd_pkg::tpd_raw_t      raw_o
);
  import tpd_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 16;

  logic [SAMPLE_BITS-1:0] hist_middle_r, hist_middle_nxt;
  logic [SAMPLE_BITS-1:0] hist_oldest_r, hist_oldest_nxt;
  logic [31:0]            baseline_r, baseline_nxt;
  logic                   raw_prev_r;

  logic [SAMPLE_BITS-1:0] diff_new_old, diff_mid_old, middle_fix;
  logic                   glitch;
  logic [31:0]            oldest_fix;
  logic signed [32:0]     base_delta;
  logic signed [16:0]     alpha_s;
  logic signed [49:0]     delta_prod;
  logic [49:0]            acc;
  logic [47:0]            thresh;
  logic [PROD_BITS-1:0]   sample_fix;
  logic                   raw;

  // glitch repair of the middle entry
  always_comb begin
    diff_new_old = (hist_oldest_r > sample) ? hist_oldest_r - sample : sample - hist_oldest_r;
    diff_mid_old = (hist_middle_r > hist_oldest_r) ? hist_middle_r - hist_oldest_r
                                                   : hist_oldest_r - hist_middle_r;
    glitch = (16'(diff_new_old) < cfg.glitch_near) && (16'(diff_mid_old) > cfg.glitch_far);
    middle_fix = glitch ? hist_oldest_r : hist_middle_r;
  end

  // baseline update: old*a + new*(1-a) written as new + (old-new)*a
  always_comb begin
    oldest_fix = 32'(hist_oldest_r) << FRAC_BITS;
    base_delta = $signed({1'b0, baseline_r}) - $signed({1'b0, oldest_fix});
    alpha_s    = $signed({1'b0, cfg.smoothing_alpha_q16});
    delta_prod = base_delta * alpha_s;
    acc        = delta_prod + {2'b00, oldest_fix, 16'h0000} + 50'h8000;
  end

  // raw press against the baseline before this step
  always_comb begin
    thresh     = baseline_r * cfg.press_ratio_q16;
    sample_fix = PROD_BITS'(sample) << (FRAC_BITS + 16);
    raw        = 48'(sample_fix) < thresh;
  end

  // baseline and oldest history entry freeze while pressed; the middle entry only takes its glitch repair
  always_comb begin
    if (!raw_prev_r) begin
      baseline_nxt    = acc[47:16];
      hist_oldest_nxt = middle_fix;
      hist_middle_nxt = sample;
    end else begin
      baseline_nxt    = baseline_r;
      hist_oldest_nxt = hist_oldest_r;
      hist_middle_nxt = middle_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_middle_r <= '0;
      hist_oldest_r <= '0;
      baseline_r    <= '0;
      raw_prev_r    <= 1'b0;
    end else if (step_en) begin
      hist_middle_r <= hist_middle_nxt;
      hist_oldest_r <= hist_oldest_nxt;
      baseline_r    <= baseline_nxt;
      raw_prev_r    <= raw;
    end
  end

  assign raw_o.raw         = raw;
  assign raw_o.raw_changed = raw != raw_prev_r;

endmodule

>>> rtl/core/tpd_debounce.sv
// tpd_debounce: holds the debounced state and the time of the last raw change
// flags a result when the debounced state flips
// depends on tpd_pkg
module tpd_debounce (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [31:0]       now_ms,
  input  logic [15:0]       debounce_ms,
  input  tpd_pkg::tpd_raw_t raw_i,
  output logic              emit,
  output logic              pressed
);
  import tpd_pkg::*;

  logic        debounced_r;
  logic [31:0] last_change_r;
  logic [31:0] elapsed;

  // wrapping elapsed time, zero when the raw state just changed
  always_comb begin
    elapsed = raw_i.raw_changed ? 32'd0 : now_ms - last_change_r;
    emit    = (elapsed > {16'd0, debounce_ms}) && (raw_i.raw != debounced_r);
    pressed = raw_i.raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounced_r   <= 1'b0;
      last_change_r <= '0;
    end else if (step_en) begin
      if (raw_i.raw_changed) begin
        last_change_r <= now_ms;
      end
      if (emit) begin
        debounced_r <= raw_i.raw;
      end
    end
  end

endmodule

>>> rtl/core/touch_press_detector.sv
// touch_press_detector: top level with configuration registers, input stage and result register
// instantiates tpd_filter and tpd_debounce; depends on tpd_pkg
//
// Takes one touch sample request per clock while the result side keeps up, and returns a
// request on the result channel only when the debounced press state flips. A sample is
// registered on acceptance and processed once the result register is free or being
// emptied; its result, if any, is loaded into the result register, which drives out_valid,
// at the end of the cycle in which it is processed. Sustained rate is one sample per cycle
// while the result side takes what it is given; it is set by the baseline update, one
// multiply and add that feeds the baseline register back for each processed sample. While
// a result is held with out_ready low, the sample in the input register waits, whether or
// not it causes a result of its own. The input then stays ready only while that register
// is empty. Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must write it only while no sample is in flight, as the block itself leaves this to them.
module touch_press_detector #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [15:0]                        in_sample,
  input  logic [31:0]                        in_now_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_pressed,
  input  logic                               cfg_we,
  input  logic [tpd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tpd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import tpd_pkg::*;

  tpd_cfg_t               cfg_r;
  logic                   s_valid_r;
  logic [SAMPLE_BITS-1:0] s_sample_r;
  logic [31:0]            s_now_r;
  logic                   out_valid_r;
  logic                   out_pressed_r;
  logic                   fire;
  logic                   emit;
  logic                   pressed;
  tpd_raw_t               raw_st;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.smoothing_alpha_q16 <= ALPHA_RST;
      cfg_r.press_ratio_q16     <= PRESS_RATIO_RST;
      cfg_r.debounce_ms         <= DEBOUNCE_RST;
      cfg_r.glitch_near         <= GLITCH_NEAR_RST;
      cfg_r.glitch_far          <= GLITCH_FAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALPHA:       cfg_r.smoothing_alpha_q16 <= cfg_wdata;
        REG_PRESS_RATIO: cfg_r.press_ratio_q16     <= cfg_wdata;
        REG_DEBOUNCE:    cfg_r.debounce_ms         <= cfg_wdata;
        REG_GLITCH_NEAR: cfg_r.glitch_near         <= cfg_wdata;
        REG_GLITCH_FAR:  cfg_r.glitch_far          <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  // stage advances when its result slot is free or being emptied
  assign fire     = s_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s_valid_r || fire;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_sample_r <= in_sample[SAMPLE_BITS-1:0];
      s_now_r    <= in_now_ms;
    end
  end

  tpd_filter #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_filter (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .sample  (s_sample_r),
    .cfg     (cfg_r),
    .raw_o   (raw_st)
  );

  tpd_debounce u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (fire),
    .now_ms      (s_now_r),
    .debounce_ms (cfg_r.debounce_ms),
    .raw_i       (raw_st),
    .emit        (emit),
    .pressed     (pressed)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_pressed_r <= pressed;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pressed = out_pressed_r;

endmodule
